// ===== rtl/core/mbd_pkg.sv =====
// shared types, constants and register codes for the multi-button debouncer
package mbd_pkg;

  localparam int unsigned NUM_BUTTONS_DEF = 10;
  localparam int unsigned LEVEL_W         = 10;
  localparam int unsigned TIMER_W         = 8;
  localparam int unsigned IN_TDATA_W      = 16;
  localparam int unsigned OUT_TDATA_W     = 16;
  localparam int unsigned CFG_IDX_W       = 2;

  typedef logic [TIMER_W-1:0] timer_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SETTLE_TICKS  = 2'd0,
    CFG_REPEAT_PERIOD = 2'd1,
    CFG_RELEASE_LIMIT = 2'd2
  } cfg_idx_t;

  localparam timer_t SETTLE_RST  = 8'd5;
  localparam timer_t PERIOD_RST  = 8'd75;
  localparam timer_t LIMIT_RST   = 8'd250;

  typedef struct packed {
    timer_t settle_ticks;
    timer_t repeat_period;
    timer_t release_limit;
  } cfg_t;

endpackage

// ===== rtl/core/multi_button_debounce_repeat_top.sv =====
// top level of the multi-button debouncer with auto-repeat
// an accepted tick's result is registered and appears on out_tdata in the next cycle
// throughput: one tick per cycle while the result slot is free or being taken; all button lanes update side by side
// the single result register refills in the cycle it is taken, so ticks flow back to back
// reset (rst_n low, synchronous): levels released, timers zero, registers 5 / 75 / 250
module multi_button_debounce_repeat_top #(
  parameter int unsigned NUM_BUTTONS = mbd_pkg::NUM_BUTTONS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream: [9:0] button_levels, rest zero
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [mbd_pkg::IN_TDATA_W-1:0]      in_tdata,
  // result stream: [9:0] press_events, [10] any_press, rest zero
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [mbd_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mbd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mbd_pkg::TIMER_W-1:0]         cfg_data
);
  import mbd_pkg::*;

  cfg_t                   cfg_r, cfg_nxt;
  logic                   in_xfer;
  logic                   out_xfer;
  logic [NUM_BUTTONS-1:0] fires;

  // configuration always taken; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SETTLE_TICKS:  cfg_nxt.settle_ticks  = cfg_data;
        CFG_REPEAT_PERIOD: cfg_nxt.repeat_period = cfg_data;
        CFG_RELEASE_LIMIT: cfg_nxt.release_limit = cfg_data;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{settle_ticks: SETTLE_RST, repeat_period: PERIOD_RST,
                 release_limit: LIMIT_RST};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // a new tick is taken whenever the result slot is free or being emptied
  assign in_tready = !out_tvalid || out_tready;
  assign in_xfer   = in_tvalid && in_tready;
  assign out_xfer  = out_tvalid && out_tready;

  // one lane per button; buttons past the field width see a released level
  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
    logic lvl;
    if (i < LEVEL_W) begin : g_in
      assign lvl = in_tdata[i];
    end else begin : g_none
      assign lvl = 1'b0;
    end
    mbd_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .step  (in_xfer),
      .level (lvl),
      .cfg   (cfg_r),
      .fire  (fires[i])
    );
  end

  mbd_merge #(.NUM_BUTTONS(NUM_BUTTONS)) u_merge (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (in_xfer),
    .drain (out_xfer),
    .fires (fires),
    .valid (out_tvalid),
    .data  (out_tdata)
  );

  // every accepted tick leaves a result waiting in the next cycle
  a_tick_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> out_tvalid)
    else $error("accepted tick produced no result");

  // any flag agrees with the event mask
  a_any_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[LEVEL_W] == (|out_tdata[LEVEL_W-1:0])))
    else $error("any_press disagrees with press_events");

  // a held result that is not taken and not replaced stays put
  a_no_silent_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid)
    else $error("result dropped while stalled");

  // padding bits stay clear
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[OUT_TDATA_W-1:LEVEL_W+1] == '0))
    else $error("result padding not zero");

endmodule

// ===== rtl/core/mbd_lane.sv =====
// one button lane: previous level, press timer, release timer and fire check
module mbd_lane (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  logic          level,
  input  mbd_pkg::cfg_t cfg,
  output logic          fire
);
  import mbd_pkg::*;

  logic   last_r, last_nxt;
  timer_t pt_r, pt_nxt;
  timer_t rt_r, rt_nxt;
  timer_t pt_mid, rt_mid, pt_inc;

  always_comb begin
    // restarts look at the timers as they stood at the start of the tick
    rt_mid = (!level && last_r && (pt_r > cfg.settle_ticks)) ? '0 : rt_r;
    pt_mid = (level && !last_r && (rt_r > cfg.settle_ticks)) ? '0 : pt_r;
    fire   = level && (pt_mid == cfg.settle_ticks) && (rt_mid > cfg.settle_ticks);
    pt_inc = pt_mid + timer_t'(1);
    pt_nxt = (pt_inc == cfg.repeat_period) ? '0 : pt_inc;
    rt_nxt = (rt_mid < cfg.release_limit) ? rt_mid + timer_t'(1) : rt_mid;
    last_nxt = level;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= 1'b0;
      pt_r   <= '0;
      rt_r   <= '0;
    end else if (step) begin
      last_r <= last_nxt;
      pt_r   <= pt_nxt;
      rt_r   <= rt_nxt;
    end
  end

endmodule

// ===== rtl/core/mbd_merge.sv =====
// merges lane fire bits into the event mask and any flag, holds the result register
module mbd_merge #(
  parameter int unsigned NUM_BUTTONS = mbd_pkg::NUM_BUTTONS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               load,
  input  logic                               drain,
  input  logic [NUM_BUTTONS-1:0]             fires,
  output logic                               valid,
  output logic [mbd_pkg::OUT_TDATA_W-1:0]    data
);
  import mbd_pkg::*;

  logic [LEVEL_W-1:0]     events;
  logic                   valid_r, valid_nxt;
  logic [OUT_TDATA_W-1:0] data_r, data_nxt;

  // lanes past the field width never reach the mask
  for (genvar j = 0; j < LEVEL_W; j++) begin : g_mask
    if (j < NUM_BUTTONS) begin : g_on
      assign events[j] = fires[j];
    end else begin : g_off
      assign events[j] = 1'b0;
    end
  end

  always_comb begin
    valid_nxt = load ? 1'b1 : (drain ? 1'b0 : valid_r);
    data_nxt  = load ? {{(OUT_TDATA_W-LEVEL_W-1){1'b0}}, |events, events} : data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign valid = valid_r;
  assign data  = data_r;

endmodule
